### hdl/ctaylor_pkg.sv
// shared constants and helpers for the taylor-series cos/sin pipeline
// no dependencies; imported by complex_exp_taylor_cos_sin and its testbench
package ctaylor_pkg;

  // fixed port widths
  localparam int ANGLE_W = 32;
  localparam int OUT_W   = 31;

  // pipeline registers per series term: two for the angle multiply,
  // three for the divide by the term index and the accumulate
  localparam int TERM_STAGES = 5;

  // log2 of the largest term index the reciprocal divider is sized for
  localparam int MAX_TERM_LOG2 = 5;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### hdl/complex_exp_taylor_cos_sin.sv
// e^(ix) as cos(x) + i sin(x) from a truncated taylor series, fully pipelined
// depends on ctaylor_pkg (widths, divider sizing, helpers)
//
// One angle request is taken in every cycle in which start is high; busy is tied low
// because nothing ever stalls. The angle is signed fixed point with FRACTION_BITS
// fraction bits, saturated to +-4.0. Each request gives exactly one result, shown for
// one cycle with out_valid high, in request order. The pipeline is made of one input
// register, five registers per series term (a split multiply of the running term by
// |x|, then a reciprocal multiply that divides by the term index, its remainder
// correction and the signed accumulate), and one output register. Throughput is one
// angle per clock. Both outputs are saturated to +-2.0 and keep the low 31 bits.
module complex_exp_taylor_cos_sin
  import ctaylor_pkg::*;
#(
  parameter int TERM_COUNT    = 16,
  parameter int FRACTION_BITS = 28
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [ANGLE_W-1:0] in_angle,
  output logic                     out_valid,
  output logic signed [OUT_W-1:0]  out_cos_part,
  output logic signed [OUT_W-1:0]  out_sin_part
);

  // ---------------------------------------------------------------------------
  // widths
  // ---------------------------------------------------------------------------
  // |x| is at most 4.0
  localparam int XW = FRACTION_BITS + 3;
  // x^k/k! peaks near 10.7 for |x| = 4, so four integer bits hold the running term
  localparam int TW = FRACTION_BITS + 4;
  // full product term * |x|, plus one bit for the rounding add
  localparam int PW = TW + XW + 1;
  // rounded product plus k/2, below 64.0
  localparam int NW = FRACTION_BITS + 6;
  // reciprocal shift and multiplier width for the divide by k
  localparam int RS = NW + MAX_TERM_LOG2;
  localparam int MW = RS + 1;
  // signed accumulators, sums stay below e^4
  localparam int AW = FRACTION_BITS + 8;
  // clamp width, never narrower than the output
  localparam int CW = max_int(AW, OUT_W);
  // angle saturation width
  localparam int LW = max_int(ANGLE_W + 1, FRACTION_BITS + 4);
  // multiply operand split points
  localparam int TH = TW / 2;
  localparam int NH = NW / 2;

  localparam logic signed [LW-1:0] ANGLE_LIM = LW'(64'd1 << (FRACTION_BITS + 2));
  localparam logic signed [CW-1:0] OUT_LIM   = CW'(64'd1 << (FRACTION_BITS + 1));
  localparam logic [TW-1:0]        ONE_TERM  = TW'(64'd1 << FRACTION_BITS);
  localparam logic signed [AW-1:0] ONE_ACC   = AW'(64'd1 << FRACTION_BITS);
  localparam logic [PW-1:0]        HALF_LSB  = PW'(64'd1 << (FRACTION_BITS - 1));

  // no backpressure anywhere: a request is taken whenever start is high
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // links between term sections; index 0 is the input register
  // ---------------------------------------------------------------------------
  logic                  v_w     [0:TERM_COUNT];
  logic [XW-1:0]         xmag_w  [0:TERM_COUNT];
  logic                  xneg_w  [0:TERM_COUNT];
  logic [TW-1:0]         term_w  [0:TERM_COUNT];
  logic signed [AW-1:0]  re_w    [0:TERM_COUNT];
  logic signed [AW-1:0]  im_w    [0:TERM_COUNT];

  // ---------------------------------------------------------------------------
  // input register: saturate the angle, split sign and magnitude
  // ---------------------------------------------------------------------------
  logic signed [LW-1:0] angle_ext;
  logic signed [LW-1:0] angle_sat;
  logic [XW-1:0]        xmag_nxt;
  logic                 xneg_nxt;

  logic                 in_v_r;
  logic [XW-1:0]        in_xmag_r;
  logic                 in_xneg_r;

  always_comb begin
    angle_ext = LW'(in_angle);
    if (angle_ext > ANGLE_LIM) begin
      angle_sat = ANGLE_LIM;
    end else if (angle_ext < -ANGLE_LIM) begin
      angle_sat = -ANGLE_LIM;
    end else begin
      angle_sat = angle_ext;
    end
    xneg_nxt = angle_sat[LW-1];
    xmag_nxt = xneg_nxt ? XW'(-angle_sat) : XW'(angle_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start;
    end
    in_xmag_r <= xmag_nxt;
    in_xneg_r <= xneg_nxt;
  end

  // series starts at t(0) = 1.0, re = 1.0, im = 0
  assign v_w[0]    = in_v_r;
  assign xmag_w[0] = in_xmag_r;
  assign xneg_w[0] = in_xneg_r;
  assign term_w[0] = ONE_TERM;
  assign re_w[0]   = ONE_ACC;
  assign im_w[0]   = '0;

  // ---------------------------------------------------------------------------
  // one five-register section per term k = g + 1
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < TERM_COUNT; g++) begin : g_term
    localparam int K = g + 1;
    // floor(2^RS / K); the estimate is low by at most one
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << RS) / K);
    localparam logic [NW-1:0] K_HALF = NW'(K / 2);
    localparam logic [5:0]    K_CMP  = 6'(K);
    // odd terms feed the sine, terms with k mod 4 of 2 or 3 are subtracted
    localparam bit ODD  = (K % 2) == 1;
    localparam bit FLIP = (K % 4) >= 2;

    // stage a: partial products of term * |x|
    logic                       a_v_r;
    logic [TW-TH+XW-1:0]        a_pph_r;
    logic [TH+XW-1:0]           a_ppl_r;
    logic [XW-1:0]              a_xmag_r;
    logic                       a_xneg_r;
    logic signed [AW-1:0]       a_re_r, a_im_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_v_r <= 1'b0;
      end else begin
        a_v_r <= v_w[g];
      end
      a_pph_r  <= (TW-TH+XW)'(term_w[g][TW-1:TH]) * (TW-TH+XW)'(xmag_w[g]);
      a_ppl_r  <= (TH+XW)'(term_w[g][TH-1:0]) * (TH+XW)'(xmag_w[g]);
      a_xmag_r <= xmag_w[g];
      a_xneg_r <= xneg_w[g];
      a_re_r   <= re_w[g];
      a_im_r   <= im_w[g];
    end

    // stage b: combine, round to nearest, add k/2 for the rounded divide
    logic [PW-1:0] prod_sum;
    logic [NW-1:0] n_nxt;

    assign prod_sum = (PW'(a_pph_r) << TH) + PW'(a_ppl_r) + HALF_LSB;
    assign n_nxt    = NW'(prod_sum >> FRACTION_BITS) + K_HALF;

    logic                 b_v_r;
    logic [NW-1:0]        b_n_r;
    logic [XW-1:0]        b_xmag_r;
    logic                 b_xneg_r;
    logic signed [AW-1:0] b_re_r, b_im_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        b_v_r <= 1'b0;
      end else begin
        b_v_r <= a_v_r;
      end
      b_n_r    <= n_nxt;
      b_xmag_r <= a_xmag_r;
      b_xneg_r <= a_xneg_r;
      b_re_r   <= a_re_r;
      b_im_r   <= a_im_r;
    end

    // stage c: partial products of n * reciprocal
    logic                 c_v_r;
    logic [NW-NH+MW-1:0]  c_qph_r;
    logic [NH+MW-1:0]     c_qpl_r;
    logic [NW-1:0]        c_n_r;
    logic [XW-1:0]        c_xmag_r;
    logic                 c_xneg_r;
    logic signed [AW-1:0] c_re_r, c_im_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v_r <= 1'b0;
      end else begin
        c_v_r <= b_v_r;
      end
      c_qph_r  <= (NW-NH+MW)'(b_n_r[NW-1:NH]) * (NW-NH+MW)'(RECIP);
      c_qpl_r  <= (NH+MW)'(b_n_r[NH-1:0]) * (NH+MW)'(RECIP);
      c_n_r    <= b_n_r;
      c_xmag_r <= b_xmag_r;
      c_xneg_r <= b_xneg_r;
      c_re_r   <= b_re_r;
      c_im_r   <= b_im_r;
    end

    // stage d: quotient estimate and its remainder
    logic [NW+MW:0] q_sum;
    logic [NW-1:0]  q0_nxt;
    logic [NW-1:0]  rem_full;

    assign q_sum    = ((NW+MW+1)'(c_qph_r) << NH) + (NW+MW+1)'(c_qpl_r);
    assign q0_nxt   = NW'(q_sum >> RS);
    assign rem_full = c_n_r - NW'(q0_nxt * NW'(K));

    logic                 d_v_r;
    logic [NW-1:0]        d_q0_r;
    logic [5:0]           d_rem_r;
    logic [XW-1:0]        d_xmag_r;
    logic                 d_xneg_r;
    logic signed [AW-1:0] d_re_r, d_im_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v_r <= 1'b0;
      end else begin
        d_v_r <= c_v_r;
      end
      d_q0_r   <= q0_nxt;
      d_rem_r  <= rem_full[5:0];
      d_xmag_r <= c_xmag_r;
      d_xneg_r <= c_xneg_r;
      d_re_r   <= c_re_r;
      d_im_r   <= c_im_r;
    end

    // stage e: correct the quotient, add the signed term to its sum
    logic [TW-1:0]        term_nxt;
    logic signed [AW-1:0] term_s;
    logic                 neg;
    logic signed [AW-1:0] re_nxt, im_nxt;

    always_comb begin
      term_nxt = TW'(d_q0_r + NW'(d_rem_r >= K_CMP));
      term_s   = AW'(term_nxt);
      neg      = (ODD && d_xneg_r) ^ FLIP;
      re_nxt   = d_re_r;
      im_nxt   = d_im_r;
      if (ODD) begin
        im_nxt = neg ? (d_im_r - term_s) : (d_im_r + term_s);
      end else begin
        re_nxt = neg ? (d_re_r - term_s) : (d_re_r + term_s);
      end
    end

    logic                 e_v_r;
    logic [TW-1:0]        e_term_r;
    logic [XW-1:0]        e_xmag_r;
    logic                 e_xneg_r;
    logic signed [AW-1:0] e_re_r, e_im_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        e_v_r <= 1'b0;
      end else begin
        e_v_r <= d_v_r;
      end
      e_term_r <= term_nxt;
      e_xmag_r <= d_xmag_r;
      e_xneg_r <= d_xneg_r;
      e_re_r   <= re_nxt;
      e_im_r   <= im_nxt;
    end

    assign v_w[g+1]    = e_v_r;
    assign term_w[g+1] = e_term_r;
    assign xmag_w[g+1] = e_xmag_r;
    assign xneg_w[g+1] = e_xneg_r;
    assign re_w[g+1]   = e_re_r;
    assign im_w[g+1]   = e_im_r;
  end

  // ---------------------------------------------------------------------------
  // output register: saturate to +-2.0, keep the low output bits
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] re_ext, im_ext;
  logic signed [CW-1:0] re_sat, im_sat;

  always_comb begin
    re_ext = CW'(re_w[TERM_COUNT]);
    im_ext = CW'(im_w[TERM_COUNT]);
    if (re_ext > OUT_LIM) begin
      re_sat = OUT_LIM;
    end else if (re_ext < -OUT_LIM) begin
      re_sat = -OUT_LIM;
    end else begin
      re_sat = re_ext;
    end
    if (im_ext > OUT_LIM) begin
      im_sat = OUT_LIM;
    end else if (im_ext < -OUT_LIM) begin
      im_sat = -OUT_LIM;
    end else begin
      im_sat = im_ext;
    end
  end

  logic                    out_v_r;
  logic signed [OUT_W-1:0] out_cos_r, out_sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= v_w[TERM_COUNT];
    end
    out_cos_r <= re_sat[OUT_W-1:0];
    out_sin_r <= im_sat[OUT_W-1:0];
  end

  assign out_valid    = out_v_r;
  assign out_cos_part = out_cos_r;
  assign out_sin_part = out_sin_r;

endmodule

### tb/complex_exp_taylor_cos_sin_tb.sv
// self-checking testbench for the taylor-series cos/sin pipeline complex_exp_taylor_cos_sin
// depends on ctaylor_pkg (port widths, stage count) and the block itself; needs nothing else
module complex_exp_taylor_cos_sin_tb;
  import ctaylor_pkg::*;

  localparam int TERM_COUNT    = 16;
  localparam int FRACTION_BITS = 28;

  // angle saturation at +-4.0 in q3.28 and output saturation at +-2.0 in q2.28
  localparam longint ANGLE_LIM = 64'sd1 <<< (FRACTION_BITS + 2);
  localparam longint OUT_LIM   = 64'sd1 <<< (FRACTION_BITS + 1);
  localparam logic signed [OUT_W-1:0] ONE_Q = 31'sd1 <<< FRACTION_BITS;

  // pipeline depth plus a margin, used for the quiet stretch at the end
  localparam int DRAIN_CYCLES = 2 + TERM_STAGES * TERM_COUNT + 8;
  // cycles without any accepted request or result before giving up
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_PER_PHASE = 234;

  typedef struct packed {
    logic signed [OUT_W-1:0] cos_part;
    logic signed [OUT_W-1:0] sin_part;
  } cos_sin_t;

  typedef struct {
    logic [ANGLE_W-1:0]      angle;
    bit                      known;     // expected value typed in below
    logic signed [OUT_W-1:0] cos_known;
    logic signed [OUT_W-1:0] sin_known;
  } angle_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic signed [ANGLE_W-1:0]  in_angle;
  logic                       out_valid;
  logic signed [OUT_W-1:0]    out_cos_part;
  logic signed [OUT_W-1:0]    out_sin_part;

  cos_sin_t pending_cos_sin[$];
  int       error_count = 0;
  int       quiet_cycles = 0;

  // directed angles: zero, one lsb either way, the +-4.0 clamp points and just beyond,
  // the most positive and most negative codes, a few familiar angles, bit patterns
  angle_row_t angle_rows [20] = '{
    '{32'h0000_0000, 1'b1, ONE_Q, 31'sd0},   // zero: series collapses to 1 + 0i
    '{32'h0000_0001, 1'b1, ONE_Q, 31'sd1},   // +1 lsb: only the linear term survives
    '{32'hFFFF_FFFF, 1'b1, ONE_Q, -31'sd1},  // -1 lsb
    '{32'h4000_0000, 1'b0, '0, '0},          // +4.0 exactly
    '{32'hC000_0000, 1'b0, '0, '0},          // -4.0 exactly
    '{32'h4000_0001, 1'b0, '0, '0},          // just above the clamp
    '{32'hBFFF_FFFF, 1'b0, '0, '0},          // just below the clamp
    '{32'h3FFF_FFFF, 1'b0, '0, '0},
    '{32'hC000_0001, 1'b0, '0, '0},
    '{32'h7FFF_FFFF, 1'b0, '0, '0},          // most positive code, saturates
    '{32'h8000_0000, 1'b0, '0, '0},          // most negative code, saturates
    '{32'h1000_0000, 1'b0, '0, '0},          // +1.0
    '{32'hF000_0000, 1'b0, '0, '0},          // -1.0
    '{32'd421657428, 1'b0, '0, '0},          // about +pi/2
    '{-32'sd421657428, 1'b0, '0, '0},        // about -pi/2
    '{32'd843314857, 1'b0, '0, '0},          // about +pi
    '{-32'sd843314857, 1'b0, '0, '0},        // about -pi
    '{32'h5555_5555, 1'b0, '0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0, '0},
    '{32'h2AAA_AAAA, 1'b0, '0, '0}
  };

  complex_exp_taylor_cos_sin #(
    .TERM_COUNT   (TERM_COUNT),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_angle    (in_angle),
    .out_valid   (out_valid),
    .out_cos_part(out_cos_part),
    .out_sin_part(out_sin_part)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cos/sin of one angle: running term t(k) = t(k-1) * |x| / k kept as a magnitude,
  // each step rounded to nearest with ties away from zero, signs applied at the sums
  function automatic cos_sin_t taylor_cos_sin(input logic signed [ANGLE_W-1:0] angle);
    longint     x;
    bit         x_neg;
    bit         term_neg;
    logic [63:0]  x_mag;
    logic [63:0]  term;
    logic [63:0]  scaled;
    logic [127:0] product;
    longint     cos_sum;
    longint     sin_sum;
    longint     signed_term;
    cos_sin_t   r;
    x = angle;
    if (x > ANGLE_LIM) x = ANGLE_LIM;
    if (x < -ANGLE_LIM) x = -ANGLE_LIM;
    x_neg = (x < 0);
    x_mag = x_neg ? 64'(-x) : 64'(x);
    term = 64'd1 << FRACTION_BITS;
    cos_sum = longint'(term);
    sin_sum = 0;
    for (int k = 1; k <= TERM_COUNT; k++) begin
      product = {64'd0, term} * {64'd0, x_mag};
      scaled = 64'((product + (128'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS);
      term = (scaled + 64'(k / 2)) / 64'(k);
      // odd powers of a negative angle flip, then the k mod 4 pattern of the series
      term_neg = x_neg && (k % 2 == 1);
      if (k % 4 == 2 || k % 4 == 3) term_neg = !term_neg;
      signed_term = term_neg ? -longint'(term) : longint'(term);
      if (k % 2 == 1) sin_sum += signed_term;
      else cos_sum += signed_term;
    end
    if (cos_sum > OUT_LIM) cos_sum = OUT_LIM;
    if (cos_sum < -OUT_LIM) cos_sum = -OUT_LIM;
    if (sin_sum > OUT_LIM) sin_sum = OUT_LIM;
    if (sin_sum < -OUT_LIM) sin_sum = -OUT_LIM;
    r.cos_part = cos_sum[OUT_W-1:0];
    r.sin_part = sin_sum[OUT_W-1:0];
    return r;
  endfunction

  // random angle: mostly inside the clamp, some tiny, some around +-4.0, some raw codes
  function automatic logic [ANGLE_W-1:0] random_angle();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    if (pick < 75) return $urandom_range(0, 2047) - 32'd1024;
    if (pick < 85) begin
      if ($urandom_range(0, 1) == 1) return 32'h4000_0000 + $urandom_range(0, 8) - 32'd4;
      return 32'hC000_0000 + $urandom_range(0, 8) - 32'd4;
    end
    return $urandom;
  endfunction

  // one angle request: optional idle cycles, then hold start until taken;
  // called right after a rising edge, so each edge sees a single drive of start
  task automatic send_angle(input logic [ANGLE_W-1:0] angle, input bit known,
                            input cos_sin_t known_result, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_angle <= angle;
    // busy is checked mid-cycle, where it holds the value the next edge will see
    @(negedge clk);
    while (busy !== 1'b0) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    if (known) pending_cos_sin.push_back(known_result);
    else pending_cos_sin.push_back(taylor_cos_sin(angle));
  endtask

  // result side: outputs are stable mid-cycle, one result per strobed cycle
  always @(negedge clk) begin
    cos_sin_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_cos_sin.size() == 0) begin
        $error("unexpected result cos_part %0d sin_part %0d", out_cos_part, out_sin_part);
        error_count++;
      end else begin
        want = pending_cos_sin.pop_front();
        if (out_cos_part !== want.cos_part) begin
          $error("cos_part expected %0d actual %0d", want.cos_part, out_cos_part);
          error_count++;
        end
        if (out_sin_part !== want.sin_part) begin
          $error("sin_part expected %0d actual %0d", want.sin_part, out_sin_part);
          error_count++;
        end
      end
    end else if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      $error("out_valid unknown after reset");
      error_count++;
    end
  end

  // watchdog: a run with neither a request nor a result accepted for too long is hung
  always @(negedge clk) begin
    if (rst_n === 1'b1) begin
      if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("complex_exp_taylor_cos_sin_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    cos_sin_t row_result;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_angle = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, sender idling lightly
    for (int i = 0; i < $size(angle_rows); i++) begin
      row_result.cos_part = angle_rows[i].cos_known;
      row_result.sin_part = angle_rows[i].sin_known;
      send_angle(angle_rows[i].angle, angle_rows[i].known, row_result, 28);
    end

    // random angles in three phases: light idling, heavy idling, back to back
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_angle(random_angle(), 1'b0, '0, 28);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_angle(random_angle(), 1'b0, '0, 61);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_angle(random_angle(), 1'b0, '0, 0);
    start <= 1'b0;

    // let the pipeline empty, then stay quiet long enough to catch stray results
    while (pending_cos_sin.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("complex_exp_taylor_cos_sin_tb OK");
    end else begin
      $display("complex_exp_taylor_cos_sin_tb NOT OK");
    end
    $finish;
  end

endmodule
